@@ rtl/swm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the sliding window maximum unit: register width and the
// command and status groups between controller and datapath. No dependencies.
package swm_pkg;

	localparam int CFG_BITS = 7;

	typedef struct packed {
		logic cfg_wr;
		logic start;
		logic expire;
		logic pop_tail;
		logic append;
	} cmd_t;

	typedef struct packed {
		logic drop;
		logic result;
	} status_t;

endpackage

@@ rtl/swm_ifs.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples, results and the window register.
// Depends on swm_pkg.
interface swm_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          start_of_sequence;

	modport source (output valid, output sample, output start_of_sequence, input ready);
	modport sink (input valid, input sample, input start_of_sequence, output ready);
endinterface

interface swm_out_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] window_max;

	modport source (output valid, output window_max, input ready);
	modport sink (input valid, input window_max, output ready);
endinterface

interface swm_cfg_if;
	import swm_pkg::*;
	logic                valid;
	logic                ready;
	logic [CFG_BITS-1:0] window_size;

	modport source (output valid, output window_size, input ready);
	modport sink (input valid, input window_size, output ready);
endinterface

@@ rtl/swm_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the sliding window maximum unit.
// Depends on swm_pkg; drives the commands of swm_datapath.
module swm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  swm_pkg::status_t status,
	output swm_pkg::cmd_t   cmd
);
	import swm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_EXPIRE = 3'b010,
		S_TRIM   = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cfg_ready = 1'b1;
				in_ready  = !cfg_valid;
				if (cfg_valid) begin
					cmd.cfg_wr = 1'b1;
				end else if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_EXPIRE;
				end
			end
			S_EXPIRE: begin
				cmd.expire = 1'b1;
				state_d    = S_TRIM;
			end
			S_TRIM: begin
				if (status.drop) begin
					cmd.pop_tail = 1'b1;
				end else if (!out_valid_q || out_ready) begin
					cmd.append = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.append) begin
				out_valid_q <= status.result;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/swm_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the sliding window maximum unit: candidate queue memory,
// history memory, pointers and the result register. Depends on swm_pkg.
module swm_datapath #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  swm_pkg::cmd_t                   cmd,
	output swm_pkg::status_t                status,
	input  logic signed [SAMPLE_BITS-1:0]   in_sample,
	input  logic                            in_sos,
	input  logic [swm_pkg::CFG_BITS-1:0]    cfg_data,
	output logic signed [SAMPLE_BITS-1:0]   out_data
);
	import swm_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int KW = $clog2(MAX_WINDOW + 1);
	localparam int WB = (KW > CFG_BITS) ? KW : CFG_BITS;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [KW-1:0] b);
		logic [KW:0] sum;
		sum = (KW+1)'(a) + (KW+1)'(b);
		if (sum >= (KW+1)'(MAX_WINDOW)) begin
			sum = sum - (KW+1)'(MAX_WINDOW);
		end
		return AW'(sum);
	endfunction

	logic signed [SAMPLE_BITS-1:0] cand_mem [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_WINDOW];

	logic [KW-1:0] k_q;
	logic [AW-1:0] head_q;
	logic [KW-1:0] count_q;
	logic [AW-1:0] hp_q;
	logic [KW-1:0] fill_q;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] rd_head_q;
	logic signed [SAMPLE_BITS-1:0] rd_tail_q;
	logic signed [SAMPLE_BITS-1:0] rd_hist_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;

	logic [WB-1:0] cfg_ext;
	logic [KW-1:0] k_next;
	logic [AW-1:0] hp_eff;
	logic [AW-1:0] head_eff;
	logic          gone_hit;
	logic [AW-1:0] head_exp;
	logic [KW-1:0] count_exp;
	logic [KW-1:0] count_dec;
	logic [KW-1:0] fill_next;
	logic [AW-1:0] hp_next;

	always_comb begin
		cfg_ext = WB'(cfg_data);
		if (cfg_ext == '0) begin
			k_next = KW'(1);
		end else if (cfg_ext > WB'(MAX_WINDOW)) begin
			k_next = KW'(MAX_WINDOW);
		end else begin
			k_next = KW'(cfg_ext);
		end
	end

	assign hp_eff   = in_sos ? '0 : hp_q;
	assign head_eff = in_sos ? '0 : head_q;

	assign gone_hit  = (fill_q >= k_q) && (count_q != '0) && (rd_head_q == rd_hist_q);
	assign head_exp  = gone_hit ? wrap_add(head_q, KW'(1)) : head_q;
	assign count_exp = gone_hit ? count_q - KW'(1) : count_q;
	assign count_dec = count_q - KW'(1);
	assign fill_next = (fill_q < k_q) ? fill_q + KW'(1) : fill_q;
	assign hp_next   = (hp_q == AW'(MAX_WINDOW - 1)) ? '0 : hp_q + AW'(1);

	assign status.drop   = (count_q != '0) && (rd_tail_q < sample_q);
	assign status.result = (fill_next >= k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= KW'(1);
			head_q  <= '0;
			count_q <= '0;
			hp_q    <= '0;
			fill_q  <= '0;
		end else begin
			priority if (cmd.cfg_wr) begin
				k_q     <= k_next;
				head_q  <= '0;
				count_q <= '0;
				hp_q    <= '0;
				fill_q  <= '0;
			end else if (cmd.start) begin
				if (in_sos) begin
					head_q  <= '0;
					count_q <= '0;
					hp_q    <= '0;
					fill_q  <= '0;
				end
			end else if (cmd.expire) begin
				head_q  <= head_exp;
				count_q <= count_exp;
			end else if (cmd.pop_tail) begin
				count_q <= count_dec;
			end else if (cmd.append) begin
				count_q <= count_q + KW'(1);
				hp_q    <= hp_next;
				fill_q  <= fill_next;
			end else begin
				k_q <= k_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sample_q  <= in_sample;
			rd_hist_q <= hist_mem[wrap_add(hp_eff, KW'(MAX_WINDOW) - k_q)];
			rd_head_q <= cand_mem[head_eff];
		end
		if (cmd.expire) begin
			rd_head_q <= cand_mem[head_exp];
			rd_tail_q <= cand_mem[wrap_add(head_exp, count_exp - KW'(1))];
		end
		if (cmd.pop_tail) begin
			rd_tail_q <= cand_mem[wrap_add(head_q, count_dec - KW'(1))];
		end
		if (cmd.append) begin
			cand_mem[wrap_add(head_q, count_q)] <= sample_q;
			hist_mem[hp_q]                      <= sample_q;
			out_data_q <= (count_q == '0) ? sample_q : rd_head_q;
		end
	end

	assign out_data = out_data_q;

endmodule

@@ rtl/sliding_window_max_unit.sv @@
`timescale 1ns / 1ps
// Sliding window maximum unit: a running maximum filter over signed samples.
// Depends on swm_pkg, swm_ifs, swm_ctrl and swm_datapath.
//
// Each sample beat passes the states S_IDLE, S_EXPIRE and S_TRIM; it stays in
// S_TRIM while smaller candidates are dropped from the tail of the queue, one
// tail entry compared per cycle through the registered reads of the candidate
// memory, and each sample is dropped from the queue at most once. Once
// window_size samples of a sequence have arrived, each sample gives one result
// beat; a start_of_sequence sample or a write of window_size begins a new
// sequence. A window of zero acts as one, and one above MAX_WINDOW is clamped.
// The result register lets the next sample enter while a result still waits.
module sliding_window_max_unit #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	swm_in_if.sink        samples,
	swm_out_if.source     results,
	swm_cfg_if.sink       cfg
);
	import swm_pkg::*;

	cmd_t    cmd;
	status_t status;

	swm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	swm_datapath #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_sample (samples.sample),
		.in_sos    (samples.start_of_sequence),
		.cfg_data  (cfg.window_size),
		.out_data  (results.window_max)
	);

endmodule
